// ===== hw/rtl/particle_sensor_frame_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// Particle sensor frame parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SENSOR_FRAME_PARSER_TOP_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_TOP_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define PSFP_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define PSFP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define PSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/psfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle sensor frame parser package
// Frame constants, field widths and the record passed from framer to result.
// ----------------------------------------------------------------------------
`default_nettype none

package psfp_pkg;

  localparam int ByteW    = 8;
  localparam int ReadingW = 15;
  localparam int PosW     = 4;

  localparam logic [ByteW-1:0] Hdr0 = 8'hFF;
  localparam logic [ByteW-1:0] Hdr1 = 8'h18;
  localparam logic [ByteW-1:0] Hdr2 = 8'h00;

  localparam logic [ReadingW-1:0] HighScale      = 15'd100;
  localparam logic [ReadingW-1:0] ThresholdReset = 15'd1150;

  // Register index of the alarm threshold.
  localparam logic RegThreshold = 1'b0;

  typedef struct packed {
    logic                valid;
    logic                good;
    logic [ReadingW-1:0] reading;
  } frame_done_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psfp_framer.sv =====
// ----------------------------------------------------------------------------
// Particle sensor frame tracker
// Hunts for the FF 18 00 header, collects the payload and the running sum.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_sensor_frame_parser_top_macros.svh"

module psfp_framer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_accept,
  input  wire logic [psfp_pkg::ByteW-1:0]    rx_byte,
  output psfp_pkg::frame_done_t              done
);

  localparam logic [psfp_pkg::PosW-1:0] PosHunt = 4'd0;
  localparam logic [psfp_pkg::PosW-1:0] PosHdr1 = 4'd1;
  localparam logic [psfp_pkg::PosW-1:0] PosHdr2 = 4'd2;
  localparam logic [psfp_pkg::PosW-1:0] PosHigh = 4'd3;
  localparam logic [psfp_pkg::PosW-1:0] PosLow  = 4'd4;
  localparam logic [psfp_pkg::PosW-1:0] PosLast = 4'd8;

  logic [psfp_pkg::PosW-1:0]     pos, pos_next;
  logic [psfp_pkg::ByteW-1:0]    sum, sum_next;
  logic [psfp_pkg::ByteW-1:0]    high_byte, high_byte_next;
  logic [psfp_pkg::ReadingW-1:0] reading, reading_next;
  logic [psfp_pkg::ByteW-1:0]    sum_plus;

  assign sum_plus = sum + rx_byte;

  always_comb begin
    pos_next       = pos;
    sum_next       = sum;
    high_byte_next = high_byte;
    reading_next   = reading;
    done.valid     = 1'b0;
    done.good      = 1'b0;
    done.reading   = reading;
    if (in_accept) begin
      case (pos)
        PosHunt: begin
          if (rx_byte == psfp_pkg::Hdr0) begin
            pos_next = PosHdr1;
            sum_next = '0;
          end
        end
        PosHdr1, PosHdr2: begin
          if (rx_byte == ((pos == PosHdr1) ? psfp_pkg::Hdr1 : psfp_pkg::Hdr2)) begin
            pos_next = pos + 4'd1;
            sum_next = sum_plus;
          end else if (rx_byte == psfp_pkg::Hdr0) begin
            // A stray FF in the header restarts the frame on this byte.
            pos_next = PosHdr1;
            sum_next = '0;
          end else begin
            pos_next = PosHunt;
          end
        end
        PosLast: begin
          // The checksum byte is good when it cancels the running sum.
          pos_next   = PosHunt;
          sum_next   = '0;
          done.valid = 1'b1;
          done.good  = (sum_plus == '0);
        end
        default: begin
          pos_next = pos + 4'd1;
          sum_next = sum_plus;
          if (pos == PosHigh) begin
            high_byte_next = rx_byte;
          end
          if (pos == PosLow) begin
            reading_next = psfp_pkg::ReadingW'({7'd0, high_byte} * psfp_pkg::HighScale)
                         + {7'd0, rx_byte};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= PosHunt;
      sum       <= '0;
      high_byte <= '0;
      reading   <= '0;
    end else begin
      pos       <= pos_next;
      sum       <= sum_next;
      high_byte <= high_byte_next;
      reading   <= reading_next;
    end
  end

  `PSFP_ASSERT_ALWAYS(a_pos_in_frame, clk, rst, pos <= PosLast)

endmodule

`default_nettype wire

// ===== hw/rtl/psfp_result.sv =====
// ----------------------------------------------------------------------------
// Particle sensor result stage
// Keeps the last good reading and alarm and holds the outgoing result item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_sensor_frame_parser_top_macros.svh"

module psfp_result (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire psfp_pkg::frame_done_t            done,
  input  wire logic [psfp_pkg::ReadingW-1:0]    threshold,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [psfp_pkg::ReadingW-1:0]         out_reading,
  output logic                                  out_alarm,
  output logic                                  out_status
);

  logic [psfp_pkg::ReadingW-1:0] last_reading;
  logic                          last_alarm;
  logic                          alarm_new;

  assign alarm_new = (done.reading > threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_reading <= '0;
      last_alarm   <= 1'b0;
    end else begin
      if (done.valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (done.valid && done.good) begin
        last_reading <= done.reading;
        last_alarm   <= alarm_new;
      end
    end
  end

  // A bad frame repeats the last good reading and alarm.
  always_ff @(posedge clk) begin
    if (done.valid) begin
      out_reading <= done.good ? done.reading : last_reading;
      out_alarm   <= done.good ? alarm_new : last_alarm;
      out_status  <= ~done.good;
    end
  end

  `PSFP_ASSERT_NEXT(a_good_result, clk, rst, done.valid && done.good,
    out_valid && !out_status && out_reading == $past(done.reading))
  `PSFP_ASSERT_NEXT(a_bad_repeats, clk, rst, done.valid && !done.good,
    out_valid && out_status && out_reading == $past(last_reading))

endmodule

`default_nettype wire

// ===== hw/rtl/particle_sensor_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// Particle sensor frame parser top level
// Output: the result item is valid in the cycle after the ninth frame byte.
// Throughput: one byte per cycle; the input stalls only while a result waits.
// The result register holds one item, which sets the stall condition.
// Reset: synchronous; hunting for the header, threshold 1150, last reading 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_sensor_frame_parser_top_macros.svh"

module particle_sensor_frame_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [14:0] reading, [15] alarm_flag, [16] frame_status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                              in_accept;
  logic [psfp_pkg::ReadingW-1:0]     threshold;
  psfp_pkg::frame_done_t             done;
  logic [psfp_pkg::ReadingW-1:0]     out_reading;
  logic                              out_alarm;
  logic                              out_status;

  assign pready    = 1'b1;
  assign s_tready  = ~m_tvalid | m_tready;
  assign in_accept = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= psfp_pkg::ThresholdReset;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == psfp_pkg::RegThreshold) begin
      threshold <= pwdata[psfp_pkg::ReadingW-1:0];
    end
  end

  assign prdata = (paddr[2] == psfp_pkg::RegThreshold) ? {17'd0, threshold} : 32'd0;

  psfp_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .rx_byte   (s_tdata),
    .done      (done)
  );

  psfp_result u_result (
    .clk         (clk),
    .rst         (rst),
    .done        (done),
    .threshold   (threshold),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_reading (out_reading),
    .out_alarm   (out_alarm),
    .out_status  (out_status)
  );

  assign m_tdata = {7'd0, out_status, out_alarm, out_reading};

  `PSFP_ASSERT_SAME(a_stall_blocks_input, clk, rst, m_tvalid && !m_tready, !s_tready)

endmodule

`default_nettype wire
